### src/rotated_sorted_array_search_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotated sorted array search block
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing when the code is synthesized.
// ----------------------------------------------------------------------------
`ifndef ROTATED_SORTED_ARRAY_SEARCH_ASSERT_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
// Assertion that is switched off while reset is high.
`define RSAS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assertion that is checked at every clock edge, reset included.
`define RSAS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RSAS_ASSERT(label, clk, rst, prop, msg)
`define RSAS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### src/rsas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotated sorted array search package
// Command codes, field widths and the control and status words that pass
// between the top level and the search engine.
// ----------------------------------------------------------------------------
package rsas_pkg;

   localparam int CMD_W   = 2;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 10;

   // Command codes of the request word.
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   // Top level to engine: start a search, take a finished answer.
   typedef struct packed {
      logic                      start;
      logic                      ack;
      logic signed [VALUE_W-1:0] target;
   } search_ctrl_type;

   // Engine to top level: activity and the finished answer.
   typedef struct packed {
      logic             busy;
      logic             done;
      logic             found;
      logic [POS_W-1:0] position;
   } search_status_type;

endpackage

### src/rsas_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one command word with its value.
// ----------------------------------------------------------------------------
interface rsas_req_if;
   import rsas_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink (input valid, input command, input value, output ready);

endinterface

### src/rsas_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one search answer word.
// ----------------------------------------------------------------------------
interface rsas_rsp_if;
   import rsas_pkg::*;

   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] position;

   modport source (output valid, output found, output position, input ready);
   modport sink (input valid, input found, input position, output ready);

endinterface

### src/rsas_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module rsas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read ports.
   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

### src/rsas_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Search engine
// Binary search over the rotated array held in the element RAM. Each halving
// step reads the left-end and middle elements and then narrows the range.
// ----------------------------------------------------------------------------
`include "rotated_sorted_array_search_assert.svh"

module rsas_engine #(
   parameter int MAX_ELEMS = 1024,
   localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1,
   localparam int CW = $clog2(MAX_ELEMS + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rsas_pkg::search_ctrl_type          ctrl,
   input  logic [CW-1:0]                      count,
   output logic [AW-1:0]                      rd_addr_a,
   output logic [AW-1:0]                      rd_addr_b,
   input  logic signed [rsas_pkg::VALUE_W-1:0] rd_data_a,
   input  logic signed [rsas_pkg::VALUE_W-1:0] rd_data_b,
   output rsas_pkg::search_status_type        status
);
   import rsas_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ISSUE = 3'd1;
   localparam logic [2:0] ST_EVAL  = 3'd2;
   localparam logic [2:0] ST_FINAL = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [AW-1:0]             lo_ff, lo_in;
   logic [AW-1:0]             hi_ff, hi_in;
   logic signed [VALUE_W-1:0] target_ff, target_in;
   logic                      found_ff, found_in;
   logic [POS_W-1:0]          pos_ff, pos_in;

   logic [AW-1:0] span;
   logic [AW-1:0] mid;
   logic          mid_hit;
   logic          low_sorted;
   logic          mid_above;
   logic          left_not_above;
   logic          keep_low;

   // Middle index of the current range.
   assign span = hi_ff - lo_ff;
   assign mid  = lo_ff + (span >> 1);

   // Port A reads the left end, port B the middle.
   assign rd_addr_a = lo_ff;
   assign rd_addr_b = mid;

   // Compares of one halving step; the data arrives in the evaluate state.
   assign mid_hit        = (rd_data_b == target_ff);
   assign low_sorted     = (rd_data_b >= rd_data_a);
   assign mid_above      = (rd_data_b > target_ff);
   assign left_not_above = (rd_data_a <= target_ff);
   assign keep_low       = low_sorted ? (mid_above && left_not_above)
                                      : (mid_above || left_not_above);

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      target_in = target_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               target_in = ctrl.target;
               lo_in     = '0;
               hi_in     = AW'(count - CW'(1));
               found_in  = 1'b0;
               pos_in    = '0;
               state_in  = (count == '0) ? ST_DONE : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            state_in = (lo_ff < hi_ff) ? ST_EVAL : ST_FINAL;
         end
         ST_EVAL: begin
            if (mid_hit) begin
               found_in = 1'b1;
               pos_in   = POS_W'(mid);
               state_in = ST_DONE;
            end else begin
               if (keep_low) begin
                  hi_in = mid;
               end else begin
                  lo_in = mid + AW'(1);
               end
               state_in = ST_ISSUE;
            end
         end
         ST_FINAL: begin
            found_in = (rd_data_a == target_ff);
            pos_in   = (rd_data_a == target_ff) ? POS_W'(lo_ff) : '0;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (ctrl.ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      target_ff <= target_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
   end

   // Status toward the top level.
   assign status.busy     = (state_ff != ST_IDLE);
   assign status.done     = (state_ff == ST_DONE);
   assign status.found    = found_ff;
   assign status.position = pos_ff;

   `RSAS_ASSERT(a_range_order, clock, reset, (state_ff == ST_EVAL) |-> (lo_ff < hi_ff), "Search range is empty in the evaluate state")
   `RSAS_ASSERT(a_done_hold, clock, reset, (state_ff == ST_DONE && !ctrl.ack) |=> (state_ff == ST_DONE), "Answer dropped before it was taken")
   `RSAS_ASSERT(a_miss_zero, clock, reset, (state_ff == ST_DONE && !found_ff) |-> (pos_ff == '0), "Miss answer carries a nonzero position")

endmodule

### src/rotated_sorted_array_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotated sorted array search
// Element store with clear, append and binary search on a rotated ascending
// array. Searches answer with a found flag and the element index.
// ----------------------------------------------------------------------------
//  Channel    Direction  Word
//  req_chan   in         command, value
//  rsp_chan   out        found, position (one word per search)
//
// Each halving step of a search reads the left-end and middle elements on
// the two RAM read ports, then compares them with the target. Synchronous
// reset empties the store at once. A finished answer waits in the output
// register while new words are taken; the engine holds a further answer
// until that register is free.
// ----------------------------------------------------------------------------
`include "rotated_sorted_array_search_assert.svh"

module rotated_sorted_array_search #(
   parameter int MAX_ELEMS = 1024
) (
   input  logic         clock,
   input  logic         reset,
   rsas_req_if.sink     req_chan,
   rsas_rsp_if.source   rsp_chan
);
   import rsas_pkg::*;

   localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
   localparam int CW = $clog2(MAX_ELEMS + 1);

   logic [CW-1:0]             count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff;
   logic [POS_W-1:0]          rsp_position_ff;

   logic                      req_take;
   logic                      wr_en;
   logic [AW-1:0]             rd_addr_a;
   logic [AW-1:0]             rd_addr_b;
   logic signed [VALUE_W-1:0] rd_data_a;
   logic signed [VALUE_W-1:0] rd_data_b;
   search_ctrl_type           ctrl;
   search_status_type         status;

   // Request side: words are taken whenever the engine is free.
   assign req_chan.ready = !status.busy;
   assign req_take       = req_chan.valid && req_chan.ready;

   // Append writes at the fill level unless the store is full.
   assign wr_en = req_take && (req_chan.command == CMD_APPEND)
                  && (count_ff < CW'(MAX_ELEMS));

   // Fill level of the store.
   always_comb begin
      count_in = count_ff;
      if (req_take && (req_chan.command == CMD_CLEAR)) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CW'(1);
      end
   end

   // Engine control.
   assign ctrl.start  = req_take && (req_chan.command == CMD_SEARCH);
   assign ctrl.target = req_chan.value;
   assign ctrl.ack    = status.done && (!rsp_valid_ff || rsp_chan.ready);

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.ack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ack) begin
         rsp_found_ff    <= status.found;
         rsp_position_ff <= status.position;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.found    = rsp_found_ff;
   assign rsp_chan.position = rsp_position_ff;

   // Element store.
   rsas_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ELEMS)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (count_ff[AW-1:0]),
      .wr_data   (req_chan.value),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (rd_data_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (rd_data_b)
   );

   // Search sequencer.
   rsas_engine #(
      .MAX_ELEMS (MAX_ELEMS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .count     (count_ff),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .status    (status)
   );

   `RSAS_ASSERT(a_count_limit, clock, reset, count_ff <= CW'(MAX_ELEMS), "Fill level exceeds the store depth")
   `RSAS_ASSERT(a_search_starts, clock, reset, ctrl.start |=> status.busy, "Accepted search did not start the engine")
   `RSAS_ASSERT(a_rsp_hold, clock, reset, (rsp_chan.valid && !rsp_chan.ready) |=> (rsp_chan.valid && $stable(rsp_chan.found) && $stable(rsp_chan.position)), "Answer word changed while it waited")

endmodule

### tb/tb_rotated_sorted_array_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the rotated sorted array search block
// Drives clear, append and search words into the block and checks every
// search answer against a predictor that mirrors the store. A directed test
// covers the corner cases, a second test fills the store to capacity, and a
// random test loads rotated ascending runs and searches them. Both channels
// see random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_rotated_sorted_array_search;
   import rsas_pkg::*;

   localparam int          STORE_DEPTH  = 1024;
   localparam int          RANDOM_WORDS = 650;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int          DRAIN_CYCLES = 64;
   localparam int          REPORT_CAP   = 40;

   // The one command code that the block ignores.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } answer_type;

   logic clock;
   logic reset;

   rsas_req_if req_if ();
   rsas_rsp_if rsp_if ();

   rotated_sorted_array_search #(
      .MAX_ELEMS (STORE_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Predictor state: a mirror of the element store and its fill level.
   logic signed [VALUE_W-1:0] mirror_store [STORE_DEPTH];
   int unsigned               mirror_count;
   answer_type                pending_answers [$];

   int unsigned cycle_count;
   int unsigned mismatch_count;
   int unsigned words_sent;
   bit          idle_off;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Gap length: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (idle_off || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_CAP)
         $display("%0t mismatch: %s", $time, msg);
   endtask

   // Binary search on the rotated array, with the same halving decisions.
   function automatic answer_type search_rotated(input logic signed [VALUE_W-1:0] target);
      int unsigned               lo;
      int unsigned               hi;
      int unsigned               mid;
      logic signed [VALUE_W-1:0] left_v;
      logic signed [VALUE_W-1:0] mid_v;
      answer_type                ans;
      ans = '0;
      if (mirror_count == 0)
         return ans;
      lo = 0;
      hi = mirror_count - 1;
      while (lo < hi) begin
         left_v = mirror_store[lo];
         mid    = lo + (hi - lo) / 2;
         mid_v  = mirror_store[mid];
         if (mid_v == target) begin
            ans.found    = 1'b1;
            ans.position = mid[POS_W-1:0];
            return ans;
         end
         if (mid_v >= left_v) begin
            // The lower part ascends.
            if (mid_v > target && left_v <= target)
               hi = mid;
            else
               lo = mid + 1;
         end else begin
            // The upper part ascends.
            if (mid_v > target || left_v <= target)
               hi = mid;
            else
               lo = mid + 1;
         end
      end
      if (mirror_store[lo] == target) begin
         ans.found    = 1'b1;
         ans.position = lo[POS_W-1:0];
      end
      return ans;
   endfunction

   // Apply one accepted word to the mirror and queue its answer, if any.
   function automatic void track_word(input logic [CMD_W-1:0] cmd,
                                      input logic signed [VALUE_W-1:0] val);
      case (cmd)
         CMD_CLEAR: mirror_count = 0;
         CMD_APPEND: begin
            if (mirror_count < STORE_DEPTH) begin
               mirror_store[mirror_count] = val;
               mirror_count++;
            end
         end
         CMD_SEARCH: pending_answers.push_back(search_rotated(val));
         default: ;
      endcase
   endfunction

   // Send one word, after a random gap, and wait until it is taken.
   task automatic send_word(input logic [CMD_W-1:0] cmd,
                            input logic signed [VALUE_W-1:0] val);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.command <= cmd;
      req_if.value   <= val;
      do
         @(posedge clock);
      while (!req_if.ready);
      track_word(cmd, val);
      if (cmd != CMD_UNUSED)
         words_sent++;
   endtask

   // Hold the sender until every queued answer has come back.
   task automatic wait_for_answers();
      req_if.valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_answers.size() != 0);
   endtask

   // Search target: mostly a stored element, else a neighbor, an extreme
   // or a random value.
   function automatic logic signed [VALUE_W-1:0] pick_target();
      int unsigned               r;
      logic signed [VALUE_W-1:0] v;
      r = $urandom_range(0, 99);
      if (mirror_count == 0 || r >= 85)
         return $urandom;
      v = mirror_store[$urandom_range(0, mirror_count - 1)];
      if (r < 60)
         return v;
      if (r < 75)
         return $urandom_range(0, 1) ? v + 1 : v - 1;
      case ($urandom_range(0, 3))
         0:       return VAL_MIN;
         1:       return VAL_MAX;
         2:       return '0;
         default: return '1;
      endcase
   endfunction

   // Append a run of distinct ascending values, rotated by a random amount.
   task automatic load_rotated_run(input int unsigned n, input bit narrow);
      logic signed [VALUE_W-1:0] raw [$];
      logic signed [VALUE_W-1:0] run [$];
      int unsigned               shift;
      repeat (n)
         raw.push_back(narrow ? int'($urandom_range(0, 200)) - 100 : int'($urandom));
      raw.sort();
      foreach (raw[i])
         if (run.size() == 0 || raw[i] != run[run.size() - 1])
            run.push_back(raw[i]);
      shift = $urandom_range(0, run.size() - 1);
      for (int i = 0; i < run.size(); i++)
         send_word(CMD_APPEND, run[(i + shift) % run.size()]);
   endtask

   // Corner cases: empty store, extremes, unused code, tiny and unsorted stores.
   task automatic test_directed();
      idle_off = 1'b0;
      send_word(CMD_SEARCH, 32'sd0);
      send_word(CMD_APPEND, 32'sd5);
      send_word(CMD_APPEND, 32'sd9);
      send_word(CMD_APPEND, VAL_MAX);
      send_word(CMD_APPEND, VAL_MIN);
      send_word(CMD_APPEND, -32'sd1);
      send_word(CMD_APPEND, 32'sd0);
      send_word(CMD_SEARCH, VAL_MAX);
      send_word(CMD_SEARCH, VAL_MIN);
      send_word(CMD_SEARCH, 32'sd0);
      send_word(CMD_SEARCH, 32'sd5);
      send_word(CMD_SEARCH, -32'sd1);
      send_word(CMD_SEARCH, 32'sd3);
      send_word(CMD_UNUSED, 32'sd5);
      send_word(CMD_SEARCH, 32'sd9);
      send_word(CMD_CLEAR, 32'sd0);
      send_word(CMD_SEARCH, 32'sd5);
      send_word(CMD_APPEND, 32'sd42);
      send_word(CMD_SEARCH, 32'sd42);
      send_word(CMD_SEARCH, -32'sd42);
      // A store that is not a rotated ascending array.
      send_word(CMD_CLEAR, VAL_MAX);
      send_word(CMD_APPEND, 32'sd7);
      send_word(CMD_APPEND, 32'sd3);
      send_word(CMD_APPEND, 32'sd11);
      send_word(CMD_SEARCH, 32'sd11);
      send_word(CMD_SEARCH, 32'sd3);
   endtask

   // Fill the store, append once more past capacity, and search across it.
   task automatic test_full_store();
      logic signed [VALUE_W-1:0] sorted [STORE_DEPTH];
      int unsigned               shift;
      idle_off = 1'b0;
      foreach (sorted[i])
         sorted[i] = VALUE_W'(longint'(VAL_MIN) + longint'(i) * 4194300
                              + $urandom_range(0, 4000));
      shift = $urandom_range(1, STORE_DEPTH - 1);
      send_word(CMD_CLEAR, 32'sd0);
      for (int i = 0; i < STORE_DEPTH; i++)
         send_word(CMD_APPEND, sorted[(i + shift) % STORE_DEPTH]);
      // This one is dropped.
      send_word(CMD_APPEND, VAL_MAX);
      send_word(CMD_SEARCH, VAL_MAX);
      send_word(CMD_SEARCH, mirror_store[0]);
      send_word(CMD_SEARCH, mirror_store[STORE_DEPTH - 1]);
      send_word(CMD_SEARCH, mirror_store[STORE_DEPTH / 2]);
      send_word(CMD_SEARCH, VAL_MIN);
      repeat (10)
         send_word(CMD_SEARCH, pick_target());
      wait_for_answers();
   endtask

   // Mostly well-formed rotated runs with searches, some broken stores and noise.
   task automatic test_random_traffic();
      int unsigned start_words;
      int unsigned pick;
      int unsigned n;
      start_words = words_sent;
      while (words_sent - start_words < RANDOM_WORDS) begin
         idle_off = ($urandom_range(0, 4) == 0);
         pick     = $urandom_range(0, 99);
         if (pick < 75) begin
            send_word(CMD_CLEAR, $urandom);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 120) : $urandom_range(1, 16);
            load_rotated_run(n, $urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 8))
               send_word(CMD_SEARCH, pick_target());
         end else if (pick < 90) begin
            if ($urandom_range(0, 1))
               send_word(CMD_CLEAR, $urandom);
            repeat ($urandom_range(1, 10))
               send_word(CMD_APPEND,
                         $urandom_range(0, 1) ? int'($urandom)
                                              : int'($urandom_range(0, 40)) - 20);
            repeat ($urandom_range(1, 5))
               send_word(CMD_SEARCH, pick_target());
         end else begin
            repeat ($urandom_range(1, 6))
               send_word(CMD_W'(CMD_UNUSED - $urandom_range(0, 3)), $urandom);
         end
         if ($urandom_range(0, 19) == 0)
            wait_for_answers();
      end
   endtask

   // Response side: ready with random stalls.
   initial begin
      int unsigned stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Check each answer word against the oldest expectation.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("answer with none expected: found %0b position %0d",
                                      rsp_if.found, rsp_if.position));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_if.found !== want.found)
               report_mismatch($sformatf("found %0b, expected %0b",
                                         rsp_if.found, want.found));
            if (rsp_if.position !== want.position)
               report_mismatch($sformatf("position %0d, expected %0d",
                                         rsp_if.position, want.position));
         end
      end
   end

   // Test sequence.
   initial begin
      cycle_count    = 0;
      mismatch_count = 0;
      words_sent     = 0;
      mirror_count   = 0;
      idle_off       = 1'b0;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.command <= CMD_CLEAR;
      req_if.value   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_full_store();
      test_random_traffic();

      wait_for_answers();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
